// File: rtl/core/tfn_pkg.sv
// Shared types and constants for the triangle face normal pipeline.
package tfn_pkg;

  // Fixed widths of the item fields
  localparam int CoordBits = 32;
  localparam int NormBits  = 32;

  // Quotient c^2 * 2^62 / S lies in 0 .. 2^62, so 63 quotient bits
  localparam int QuotBits  = 63;
  // Integer square root of a 63-bit radicand, padded to 64 bits
  localparam int RadBits   = 64;
  localparam int RootBits  = 32;

  // Pipeline depth of the cross product lane
  localparam int CrossLat  = 4;

  typedef struct packed {
    logic [CoordBits-1:0] v0_x;
    logic [CoordBits-1:0] v0_y;
    logic [CoordBits-1:0] v0_z;
    logic [CoordBits-1:0] v1_x;
    logic [CoordBits-1:0] v1_y;
    logic [CoordBits-1:0] v1_z;
    logic [CoordBits-1:0] v2_x;
    logic [CoordBits-1:0] v2_y;
    logic [CoordBits-1:0] v2_z;
  } tri_in_t;

  typedef struct packed {
    logic signed [NormBits-1:0] normal_x;
    logic signed [NormBits-1:0] normal_y;
    logic signed [NormBits-1:0] normal_z;
    logic                       degenerate;
  } norm_out_t;

  // Per-component flags carried down the normalising lanes
  typedef struct packed {
    logic neg;
    logic zero;
  } comp_flags_t;

endpackage

// File: rtl/core/tfn_cross_lane.sv
// One cross product component and its exact square.
module tfn_cross_lane import tfn_pkg::*; #(
  parameter int W = 33
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   a1,
  input  logic signed [W-1:0]   b2,
  input  logic signed [W-1:0]   a2,
  input  logic signed [W-1:0]   b1,
  output logic                  neg,
  output logic [4*W-1:0]        sq
);

  logic signed [2*W-1:0] p;
  logic signed [2*W-1:0] q;
  logic signed [2*W:0]   diff;
  logic signed [2*W:0]   diff_neg;
  logic [2*W-1:0]        mag_c;
  logic [2*W-1:0]        hh;
  logic [2*W-1:0]        hl;
  logic [2*W-1:0]        ll;
  logic                  neg1;
  logic                  neg2;

  // Take both partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p <= a1 * b2;
      q <= a2 * b1;
    end
  end

  // Subtract them
  always_ff @(posedge clk) begin
    if (en) begin
      diff <= (2*W+1)'(p) - (2*W+1)'(q);
    end
  end

  // Split the magnitude into halves for squaring
  assign diff_neg = -diff;
  assign mag_c    = diff[2*W] ? diff_neg[2*W-1:0] : diff[2*W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      hh   <= mag_c[2*W-1:W] * mag_c[2*W-1:W];
      hl   <= mag_c[2*W-1:W] * mag_c[W-1:0];
      ll   <= mag_c[W-1:0] * mag_c[W-1:0];
      neg1 <= diff[2*W];
    end
  end

  // Combine the partial squares
  always_ff @(posedge clk) begin
    if (en) begin
      sq   <= {hh, {(2*W){1'b0}}} + ((4*W)'(hl) << (W + 1)) + (4*W)'(ll);
      neg2 <= neg1;
    end
  end

  assign neg = neg2;

endmodule

// File: rtl/core/tfn_merge.sv
// Merge of the three lane squares into the squared length.
module tfn_merge import tfn_pkg::*; #(
  parameter int SW = 132
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [2:0][SW-1:0]     sq_in,
  input  logic [2:0]             neg_in,
  output logic [SW-1:0]          len_sq,
  output logic [2:0][SW-1:0]     sq_out,
  output comp_flags_t [2:0]      flags
);

  logic zero_c;

  // Zero length only when every component is zero
  assign zero_c = (sq_in[0] == '0) && (sq_in[1] == '0) && (sq_in[2] == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      len_sq <= sq_in[0] + sq_in[1] + sq_in[2];
      sq_out <= sq_in;
      for (int i = 0; i < 3; i++) begin
        flags[i].neg  <= neg_in[i];
        flags[i].zero <= zero_c;
      end
    end
  end

endmodule

// File: rtl/core/tfn_unit_lane.sv
// Exact scaling of one component: restoring divide, square root, rounding.
module tfn_unit_lane import tfn_pkg::*; #(
  parameter int SW = 132
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [SW-1:0]               c_sq,
  input  logic [SW-1:0]               len_sq,
  input  comp_flags_t                 flags_in,
  output logic signed [NormBits-1:0]  norm
);

  logic [SW-1:0]         rem  [0:QuotBits];
  logic [SW-1:0]         dvs  [0:QuotBits];
  logic [QuotBits-1:0]   quo  [0:QuotBits];
  comp_flags_t           dfl  [0:QuotBits];

  logic [RootBits+1:0]   rrem [0:RootBits];
  logic [RootBits-1:0]   root [0:RootBits];
  logic [RadBits-1:0]    rad  [0:RootBits];
  comp_flags_t           sfl  [0:RootBits];

  logic [RootBits:0]     rnd;
  logic [RootBits-1:0]   qmag;

  assign rem[0] = c_sq;
  assign dvs[0] = len_sq;
  assign quo[0] = '0;
  assign dfl[0] = flags_in;

  // Divide: one quotient bit per stage
  for (genvar k = 0; k < QuotBits; k++) begin : g_div
    logic [SW:0] trial;
    logic [SW:0] sub;
    logic        ge;
    if (k == 0) begin : g_first
      assign trial = {1'b0, rem[k]};
    end else begin : g_rest
      assign trial = {rem[k], 1'b0};
    end
    assign ge  = trial >= {1'b0, dvs[k]};
    assign sub = trial - {1'b0, dvs[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? sub[SW-1:0] : trial[SW-1:0];
        dvs[k+1] <= dvs[k];
        quo[k+1] <= {quo[k][QuotBits-2:0], ge};
        dfl[k+1] <= dfl[k];
      end
    end
  end

  assign rrem[0] = '0;
  assign root[0] = '0;
  assign rad[0]  = RadBits'(quo[QuotBits]);
  assign sfl[0]  = dfl[QuotBits];

  // Square root: one root bit per stage
  for (genvar i = 0; i < RootBits; i++) begin : g_sqrt
    logic [RootBits+3:0] cur;
    logic [RootBits+3:0] trial;
    logic [RootBits+3:0] sub;
    logic                ge;
    assign cur   = {rrem[i], rad[i][RadBits-1:RadBits-2]};
    assign trial = (RootBits+4)'({root[i], 2'b01});
    assign ge    = cur >= trial;
    assign sub   = cur - trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rrem[i+1] <= ge ? sub[RootBits+1:0] : cur[RootBits+1:0];
        root[i+1] <= {root[i][RootBits-2:0], ge};
        rad[i+1]  <= rad[i] << 2;
        sfl[i+1]  <= sfl[i];
      end
    end
  end

  // Round to nearest odd bound and apply the sign
  assign rnd  = (RootBits+1)'(root[RootBits]) + (RootBits+1)'(1);
  assign qmag = rnd[RootBits:1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (sfl[RootBits].zero) begin
        norm <= '0;
      end else if (sfl[RootBits].neg) begin
        norm <= -$signed(qmag);
      end else begin
        norm <= $signed(qmag);
      end
    end
  end

endmodule

// File: rtl/core/triangle_face_normal_top.sv
// Triangle face normal: edges, cross product lanes, merge and exact unit scaling.
// Path: edge register, cross product lanes, merge, divide, square root, output register.
// Throughput: one item per cycle unless stalled; divide and square root fully pipelined.
// The whole pipeline advances unless the output register holds a stalled item.
// Reset clears the valid pipeline only; payload registers are not reset.
module triangle_face_normal_top import tfn_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  tri_in_t   in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output norm_out_t out_data
);

  localparam int W   = COORD_WIDTH + 1;
  localparam int SW  = 4 * W;
  localparam int Lat = 1 + CrossLat + 1 + QuotBits + RootBits + 1;

  logic [8:0][CoordBits-1:0]      raw;
  logic signed [COORD_WIDTH-1:0]  cv [0:8];
  logic signed [W-1:0]            e1 [0:2];
  logic signed [W-1:0]            e2 [0:2];
  logic                           adv;
  logic [Lat-1:0]                 vld;
  logic [2:0][SW-1:0]             sq;
  logic [2:0]                     neg;
  logic [SW-1:0]                  len_sq;
  logic [2:0][SW-1:0]             sq_m;
  comp_flags_t [2:0]              flags;
  logic signed [NormBits-1:0]     norm [0:2];

  // Advance unless the output holds a stalled item
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Read the low coordinate bits of each field, sign at the top bit
  assign raw = in_data;
  for (genvar i = 0; i < 9; i++) begin : g_coord
    if (COORD_WIDTH <= CoordBits) begin : g_trunc
      assign cv[i] = raw[8-i][COORD_WIDTH-1:0];
    end else begin : g_ext
      assign cv[i] = {{(COORD_WIDTH-CoordBits){raw[8-i][CoordBits-1]}}, raw[8-i]};
    end
  end

  // Form both edges from the first vertex
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= W'(cv[3+i]) - W'(cv[i]);
        e2[i] <= W'(cv[6+i]) - W'(cv[i]);
      end
    end
  end

  // Valid flags follow the items down the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Lat-2:0], in_valid};
    end
  end

  tfn_cross_lane #(.W(W)) u_cross_x (
    .clk(clk), .en(adv), .a1(e1[1]), .b2(e2[2]), .a2(e1[2]), .b1(e2[1]),
    .neg(neg[0]), .sq(sq[0])
  );

  tfn_cross_lane #(.W(W)) u_cross_y (
    .clk(clk), .en(adv), .a1(e1[2]), .b2(e2[0]), .a2(e1[0]), .b1(e2[2]),
    .neg(neg[1]), .sq(sq[1])
  );

  tfn_cross_lane #(.W(W)) u_cross_z (
    .clk(clk), .en(adv), .a1(e1[0]), .b2(e2[1]), .a2(e1[1]), .b1(e2[0]),
    .neg(neg[2]), .sq(sq[2])
  );

  tfn_merge #(.SW(SW)) u_merge (
    .clk(clk), .en(adv), .sq_in(sq), .neg_in(neg),
    .len_sq(len_sq), .sq_out(sq_m), .flags(flags)
  );

  for (genvar i = 0; i < 3; i++) begin : g_unit
    tfn_unit_lane #(.SW(SW)) u_unit (
      .clk(clk), .en(adv), .c_sq(sq_m[i]), .len_sq(len_sq),
      .flags_in(flags[i]), .norm(norm[i])
    );
  end

  // Degenerate flag travels with the lane flags
  logic deg [0:QuotBits+RootBits+1];
  assign deg[0] = flags[0].zero;
  for (genvar k = 0; k < QuotBits + RootBits + 1; k++) begin : g_deg
    always_ff @(posedge clk) begin
      if (adv) begin
        deg[k+1] <= deg[k];
      end
    end
  end

  assign out_valid           = vld[Lat-1];
  assign out_data.normal_x   = norm[0];
  assign out_data.normal_y   = norm[1];
  assign out_data.normal_z   = norm[2];
  assign out_data.degenerate = deg[QuotBits+RootBits+1];

  // A degenerate item carries a zero normal
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |->
      out_data.normal_x == 0 && out_data.normal_y == 0 && out_data.normal_z == 0)
    else $error("degenerate item with nonzero normal");

  // A proper normal is never all zero
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.degenerate |->
      out_data.normal_x != 0 || out_data.normal_y != 0 || out_data.normal_z != 0)
    else $error("zero normal on proper triangle");

  // The x and z components stay within unit range
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      out_data.normal_x <= 32'sd1073741824 && out_data.normal_x >= -32'sd1073741824 &&
      out_data.normal_z <= 32'sd1073741824 && out_data.normal_z >= -32'sd1073741824)
    else $error("normal component out of range");

  // Reset empties the pipeline
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid result after reset");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the triangle face normal pipeline.
`timescale 1ns / 1ps

module tb_top;
  import tfn_pkg::*;

  localparam int ResultLat = 102;
  localparam int IdleLimit = 4000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  tri_in_t   in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  norm_out_t out_data;

  tri_in_t   tri_q[$];
  norm_out_t normal_q[$];
  int        errors = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        items_sent = 0;
  int        idle_cycles = 0;
  bit        calm = 1'b0;

  triangle_face_normal_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Exact unit normal: cross product of the edges, scaled to 2^30 and rounded
  function automatic norm_out_t face_normal(tri_in_t t);
    logic signed [33:0] e1x, e1y, e1z, e2x, e2y, e2z;
    logic signed [67:0] cr[3];
    logic signed [67:0] a;
    logic [255:0] mag[3];
    logic [255:0] sum_sq, target, k, sq;
    logic [63:0]  lo, hi, mid;
    norm_out_t r;
    e1x = $signed(t.v1_x) - $signed(t.v0_x);
    e1y = $signed(t.v1_y) - $signed(t.v0_y);
    e1z = $signed(t.v1_z) - $signed(t.v0_z);
    e2x = $signed(t.v2_x) - $signed(t.v0_x);
    e2y = $signed(t.v2_y) - $signed(t.v0_y);
    e2z = $signed(t.v2_z) - $signed(t.v0_z);
    cr[0] = e1y * e2z - e1z * e2y;
    cr[1] = e1z * e2x - e1x * e2z;
    cr[2] = e1x * e2y - e1y * e2x;
    sum_sq = '0;
    for (int i = 0; i < 3; i++) begin
      a = (cr[i] < 0) ? -cr[i] : cr[i];
      mag[i] = {188'd0, a};
      sum_sq = sum_sq + mag[i] * mag[i];
    end
    r = '0;
    if (sum_sq == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      // largest q with (2q-1)^2 * S <= c^2 * 2^62
      target = (mag[i] * mag[i]) << 62;
      lo = 0;
      hi = 64'd1 << 30;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        k = {192'd0, 2 * mid - 1};
        sq = k * k * sum_sq;
        if (sq <= target) lo = mid;
        else hi = mid - 1;
      end
      if (i == 0) r.normal_x = (cr[i] < 0) ? -lo[31:0] : lo[31:0];
      if (i == 1) r.normal_y = (cr[i] < 0) ? -lo[31:0] : lo[31:0];
      if (i == 2) r.normal_z = (cr[i] < 0) ? -lo[31:0] : lo[31:0];
    end
    return r;
  endfunction

  function automatic int draw_wait();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic tri_in_t make_tri(logic [31:0] c[9]);
    tri_in_t t;
    t = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]};
    return t;
  endfunction

  // Append one triangle to the pending items
  task automatic queue_tri(logic [31:0] c[9]);
    tri_q.insert(tri_q.size(), make_tri(c));
  endtask

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return 32'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  // Drive the next item, holding it until accepted
  always @(posedge clk) begin
    logic    nv;
    tri_in_t nd;
    int      ng;
    nv = in_valid;
    nd = in_data;
    ng = gap_left;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        normal_q.insert(normal_q.size(), face_normal(in_data));
        nv = 1'b0;
      end
      if (!nv) begin
        if (ng > 0) begin
          ng--;
        end else if (tri_q.size() > 0) begin
          nd = tri_q.pop_front();
          nv = 1'b1;
          ng = draw_wait();
          items_sent++;
          if (items_sent % 150 == 0) calm <= ~calm;
        end
      end
    end
    in_valid <= nv;
    in_data  <= nd;
    gap_left <= ng;
  end

  // Check each result against the oldest expectation; stall at random
  always @(posedge clk) begin
    int        ns;
    norm_out_t want;
    ns = stall_left;
    if (!rst && out_valid && !out_stall) begin
      if (normal_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = normal_q.pop_front();
        if (out_data.normal_x !== want.normal_x) begin
          $display("%0t: normal_x expected %0d actual %0d", $time,
                   want.normal_x, out_data.normal_x);
          errors++;
        end
        if (out_data.normal_y !== want.normal_y) begin
          $display("%0t: normal_y expected %0d actual %0d", $time,
                   want.normal_y, out_data.normal_y);
          errors++;
        end
        if (out_data.normal_z !== want.normal_z) begin
          $display("%0t: normal_z expected %0d actual %0d", $time,
                   want.normal_z, out_data.normal_z);
          errors++;
        end
        if (out_data.degenerate !== want.degenerate) begin
          $display("%0t: degenerate expected %0b actual %0b", $time,
                   want.degenerate, out_data.degenerate);
          errors++;
        end
      end
      ns = draw_wait();
    end else if (ns > 0) begin
      ns--;
    end
    stall_left <= ns;
    out_stall  <= !rst && ns > 0;
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] c[9];
    logic [31:0] mx, mn, one;
    int mode;
    mx  = 32'h7FFF_FFFF;
    mn  = 32'h8000_0000;
    one = 32'h0001_0000;

    // Directed: degenerate, axis aligned, extremes, collinear
    c = '{default: 32'd0};
    queue_tri(c);
    c = '{0, 0, 0, one, 0, 0, 0, one, 0};
    queue_tri(c);
    c = '{0, 0, 0, 0, one, 0, one, 0, 0};
    queue_tri(c);
    c = '{0, 0, 0, 0, one, 0, 0, 0, one};
    queue_tri(c);
    c = '{0, 0, 0, 0, 0, one, 0, one, 0};
    queue_tri(c);
    c = '{0, 0, 0, 0, 0, one, one, 0, 0};
    queue_tri(c);
    c = '{0, 0, 0, one, 0, 0, 0, 0, one};
    queue_tri(c);
    c = '{mn, mn, mn, mx, mn, mn, mn, mx, mn};
    queue_tri(c);
    c = '{mx, mx, mx, mn, mx, mx, mx, mn, mx};
    queue_tri(c);
    c = '{mn, mn, mn, mx, mx, mn, mn, mx, mx};
    queue_tri(c);
    c = '{mn, mx, mn, mx, mn, mx, mx, mx, mn};
    queue_tri(c);
    c = '{mn, mn, mn, mx, mx, mx, mn, mn, mn};
    queue_tri(c);
    c = '{0, 0, 0, one, one, one, 2 * one, 2 * one, 2 * one};
    queue_tri(c);
    c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    queue_tri(c);
    c = '{0, 0, 0, one, one, 0, one, -one, 0};
    queue_tri(c);
    c = '{mx, mx, mx, mx, mx, mx, mx, mx, mx};
    queue_tri(c);
    c = '{0, 0, 0, one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one};
    queue_tri(c);

    // Random: wide, unit scale and small coordinates, with degenerate shapes
    for (int n = 0; n < 1400; n++) begin
      mode = $urandom_range(0, 2);
      for (int i = 0; i < 9; i++) c[i] = rnd_coord(mode);
      case ($urandom_range(0, 9))
        0: for (int i = 0; i < 3; i++) c[3 + i] = c[i];
        1: for (int i = 0; i < 3; i++) c[6 + i] = c[3 + i];
        2: for (int i = 0; i < 3; i++) c[6 + i] = c[i] + 2 * (c[3 + i] - c[i]);
        3: begin
          c[2] = c[0]; c[5] = c[0]; c[8] = c[0];
        end
        default: ;
      endcase
      queue_tri(c);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Drain and allow the pipeline to settle
    wait (tri_q.size() == 0 && !in_valid && normal_q.size() == 0);
    repeat (ResultLat + 20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/tfn_pkg.sv
rtl/core/tfn_cross_lane.sv
rtl/core/tfn_merge.sv
rtl/core/tfn_unit_lane.sv
rtl/core/triangle_face_normal_top.sv
tb/tb_top.sv
